### hdl/rrts_pkg.sv
// Shared types and constants for the round-robin task slot scheduler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rrts_pkg;

	localparam int unsigned RRTS_SLOT_COUNT  = 10;
	localparam int unsigned RRTS_ENTRY_WIDTH = 32;
	localparam int unsigned SLOT_FIELD_W     = 4;

	typedef enum logic [1:0] {
		OP_SPAWN    = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_YIELD    = 2'd2,
		OP_FINISH   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_RUNNING  = 2'd0,
		ST_FINISHED = 2'd1,
		ST_READY    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_WRITE  = 4'b0100,
		S_REPORT = 4'b1000
	} state_t;

	// Broadcast control from the sequencer to every slot cell
	typedef struct packed {
		logic    shift;
		status_t want;
		logic    wr_en;
		status_t wr_status;
		logic    entry_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### hdl/rrts_in_if.sv
// Input channel of the scheduler: valid/ready handshake with operation and entry.
// Depends on rrts_pkg for the default entry width and the operation type.
`default_nettype none

interface rrts_in_if import rrts_pkg::*; #(
	parameter int unsigned ENTRY_WIDTH = RRTS_ENTRY_WIDTH
);
	logic                   valid;
	logic                   ready;
	op_t                    operation;
	logic [ENTRY_WIDTH-1:0] entry_address;

	modport source (output valid, output operation, output entry_address, input ready);
	modport sink   (input valid, input operation, input entry_address, output ready);
endinterface

`default_nettype wire

### hdl/rrts_out_if.sv
// Result channel of the scheduler: valid/ready handshake with one result item.
// Depends on rrts_pkg for the default entry width and slot field width.
`default_nettype none

interface rrts_out_if import rrts_pkg::*; #(
	parameter int unsigned ENTRY_WIDTH = RRTS_ENTRY_WIDTH
);
	logic                    valid;
	logic                    ready;
	logic                    success;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [ENTRY_WIDTH-1:0]  dispatched_entry;
	logic                    all_finished;

	modport source (output valid, output success, output slot, output dispatched_entry,
		output all_finished, input ready);
	modport sink   (input valid, input success, input slot, input dispatched_entry,
		input all_finished, output ready);
endinterface

`default_nettype wire

### hdl/round_robin_task_slot_scheduler.sv
// Round-robin task slot scheduler. Spawn, dispatch, yield and finish each return one
// result item. A row of slot cells holds the table; a search token enters the row at
// the slot after the current one and moves one cell per cycle, wrapping at the used
// count. Dispatch on a non-empty table and spawn on a full table search the row;
// plain spawn, yield, finish and dispatch on an empty table go straight to the
// write step. A result waits in the report state while the output register is
// full, and the next item is accepted once the result has loaded. One item is
// worked on at a time; the next is accepted while a result waits in the output
// register. Depends on rrts_pkg, rrts_in_if, rrts_out_if and rrts_cell.
`default_nettype none

module round_robin_task_slot_scheduler import rrts_pkg::*; #(
	parameter int unsigned SLOT_COUNT  = RRTS_SLOT_COUNT,
	parameter int unsigned ENTRY_WIDTH = RRTS_ENTRY_WIDTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rrts_in_if.sink    in_ch,
	rrts_out_if.source out_ch
);

	localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
	localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

	state_t                 state_q;
	op_t                    op_q;
	status_t                want_q;
	logic [ENTRY_WIDTH-1:0] entry_in_q;
	logic [CNT_W-1:0]       used_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       cur_q;
	logic                   cur_valid_q;
	logic [IDX_W-1:0]       pick_q;
	logic                   ok_q;
	logic                   res_success_q;
	logic [IDX_W-1:0]       res_slot_q;
	logic [ENTRY_WIDTH-1:0] res_entry_q;

	logic                    out_valid_q;
	logic                    out_success_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;
	logic [ENTRY_WIDTH-1:0]  out_entry_q;
	logic                    out_all_fin_q;

	cell_ctrl_t             ctrl;
	logic [SLOT_COUNT-1:0]  inject_vec;
	logic [SLOT_COUNT-1:0]  tok_in_vec;
	logic [SLOT_COUNT-1:0]  sel_vec;
	logic [SLOT_COUNT-1:0]  used_vec;
	logic [SLOT_COUNT-1:0]  tok_vec;
	logic [SLOT_COUNT-1:0]  hit_vec;
	logic [SLOT_COUNT-1:0]  done_vec;
	status_t                status_vec [SLOT_COUNT];
	logic [ENTRY_WIDTH-1:0] entry_vec  [SLOT_COUNT];

	logic             accept;
	logic             full;
	logic             start_scan;
	logic [CNT_W-1:0] cur_next;
	logic [CNT_W-1:0] start_idx;
	logic [IDX_W-1:0] hit_idx;
	logic             load_out;

	assign accept   = in_ch.valid && in_ch.ready;
	assign full     = (used_q == CNT_W'(SLOT_COUNT));
	assign load_out = (state_q == S_REPORT) && (!out_valid_q || out_ch.ready);

	// a search is needed for dispatch on a non-empty table, and for spawn once the table is full
	assign start_scan = accept && (used_q != '0) &&
		((in_ch.operation == OP_DISPATCH) || ((in_ch.operation == OP_SPAWN) && full));

	assign cur_next  = CNT_W'(cur_q) + CNT_W'(1);
	assign start_idx = (!cur_valid_q || (cur_next == used_q)) ? '0 : cur_next;

	always_comb begin
		// advance the token only while the search goes on; drop it when the search ends
		ctrl.shift     = (state_q == S_SCAN) && (hit_vec == '0) && (cnt_q != used_q);
		ctrl.want      = want_q;
		ctrl.wr_en     = (state_q == S_WRITE) && ok_q;
		ctrl.wr_status = ST_READY;
		ctrl.entry_en  = 1'b0;
		unique case (op_q)
			OP_SPAWN: begin
				ctrl.wr_status = ST_READY;
				ctrl.entry_en  = 1'b1;
			end
			OP_DISPATCH: ctrl.wr_status = ST_RUNNING;
			OP_YIELD:    ctrl.wr_status = ST_READY;
			OP_FINISH:   ctrl.wr_status = ST_FINISHED;
			default:     ctrl.wr_status = ST_READY;
		endcase
	end

	always_comb begin
		hit_idx       = '0;
		tok_in_vec[0] = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			inject_vec[i] = start_scan && (start_idx == CNT_W'(i));
			sel_vec[i]    = (pick_q == IDX_W'(i));
			used_vec[i]   = (CNT_W'(i) < used_q);
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
			// the last used cell hands its token back to cell zero
			if (CNT_W'(i) + CNT_W'(1) == used_q) begin
				tok_in_vec[0] = tok_in_vec[0] | tok_vec[i];
			end
			if (i > 0) begin
				tok_in_vec[i] = tok_vec[i-1] && (CNT_W'(i) != used_q);
			end
		end
	end

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		rrts_cell #(
			.ENTRY_WIDTH (ENTRY_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.inject   (inject_vec[g]),
			.tok_in   (tok_in_vec[g]),
			.sel      (sel_vec[g]),
			.used     (used_vec[g]),
			.wr_entry (entry_in_q),
			.tok      (tok_vec[g]),
			.hit      (hit_vec[g]),
			.done     (done_vec[g]),
			.status   (status_vec[g]),
			.entry    (entry_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= start_scan ? S_SCAN : S_WRITE;
					end
				end
				S_SCAN: begin
					if ((hit_vec != '0) || (cnt_q == used_q)) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (ok_q && (op_q == OP_SPAWN) && !full) begin
						used_q <= used_q + CNT_W'(1);
					end
					if (ok_q && (op_q == OP_DISPATCH)) begin
						cur_q       <= pick_q;
						cur_valid_q <= 1'b1;
					end
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and search bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= in_ch.operation;
			entry_in_q <= in_ch.entry_address;
			cnt_q      <= CNT_W'(1);
			want_q     <= (in_ch.operation == OP_SPAWN) ? ST_FINISHED : ST_READY;
			unique case (in_ch.operation)
				OP_SPAWN: begin
					pick_q <= used_q[IDX_W-1:0];
					ok_q   <= !full;
				end
				OP_DISPATCH: begin
					pick_q <= '0;
					ok_q   <= 1'b0;
				end
				OP_YIELD: begin
					pick_q <= cur_q;
					ok_q   <= cur_valid_q && (status_vec[cur_q] == ST_RUNNING);
				end
				default: begin
					pick_q <= cur_q;
					ok_q   <= cur_valid_q;
				end
			endcase
		end else if (state_q == S_SCAN) begin
			if (hit_vec != '0) begin
				pick_q <= hit_idx;
				ok_q   <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
		if (state_q == S_WRITE) begin
			res_success_q <= ok_q && ((op_q == OP_SPAWN) || (op_q == OP_DISPATCH));
			res_slot_q    <= (ok_q && ((op_q == OP_SPAWN) || (op_q == OP_DISPATCH))) ?
				pick_q : '0;
			res_entry_q   <= (ok_q && (op_q == OP_DISPATCH)) ? entry_vec[pick_q] : '0;
		end
		if (load_out) begin
			out_success_q <= res_success_q;
			out_slot_q    <= SLOT_FIELD_W'(res_slot_q);
			out_entry_q   <= res_entry_q;
			out_all_fin_q <= &done_vec;
		end
	end

	assign in_ch.ready             = (state_q == S_IDLE);
	assign out_ch.valid            = out_valid_q;
	assign out_ch.success          = out_success_q;
	assign out_ch.slot             = out_slot_q;
	assign out_ch.dispatched_entry = out_entry_q;
	assign out_ch.all_finished     = out_all_fin_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok_vec))
		else $error("more than one search token in the slot row");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(hit_vec))
		else $error("more than one slot matched in one search step");

	a_token_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE || state_q == S_REPORT) |-> (tok_vec == '0))
		else $error("search token left in the row after the search");

	a_current_used: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (CNT_W'(cur_q) < used_q))
		else $error("current slot lies beyond the used slots");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && op_q == OP_SPAWN && ok_q && !full) |=>
		(used_q == $past(used_q) + CNT_W'(1)))
		else $error("spawn into a free slot did not grow the used count");

endmodule

`default_nettype wire

### hdl/rrts_cell.sv
// One task slot: status, entry address and the search token that walks the row.
// Depends on rrts_pkg for status_t and cell_ctrl_t.
`default_nettype none

module rrts_cell import rrts_pkg::*; #(
	parameter int unsigned ENTRY_WIDTH = RRTS_ENTRY_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cell_ctrl_t             ctrl,
	input  wire logic                   inject,
	input  wire logic                   tok_in,
	input  wire logic                   sel,
	input  wire logic                   used,
	input  wire logic [ENTRY_WIDTH-1:0] wr_entry,
	output logic                        tok,
	output logic                        hit,
	output logic                        done,
	output status_t                     status,
	output logic [ENTRY_WIDTH-1:0]      entry
);

	status_t                status_q;
	logic                   tok_q;
	logic [ENTRY_WIDTH-1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_RUNNING;
			tok_q    <= 1'b0;
		end else begin
			// token enters at the scan start, then moves one cell per cycle while ctrl.shift is set
			tok_q <= inject | (ctrl.shift & tok_in);
			if (sel && ctrl.wr_en) begin
				status_q <= ctrl.wr_status;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && ctrl.wr_en && ctrl.entry_en) begin
			entry_q <= wr_entry;
		end
	end

	assign tok    = tok_q;
	assign hit    = tok_q && (status_q == ctrl.want);
	assign done   = !used || (status_q == ST_FINISHED);
	assign status = status_q;
	assign entry  = entry_q;

endmodule

`default_nettype wire
